// ----- rtl/core/pds_pkg.sv -----
// ---------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the PID controller with dead band and
// integral separation.
// ---------------------------------------------------------------------------
package pds_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 16;  // input sample and output drive
    localparam int GAIN_W    = 16;  // Q8.8 gains, setpoint
    localparam int MAG_W     = 15;  // limit, dead band, threshold
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // arithmetic widths
    localparam int MUL_A_W    = 17;  // signed gain or Q1.15 weight
    localparam int DERIV_W    = 32;  // derivative term and its filter state
    localparam int WIDE_W     = 33;  // error before saturation
    localparam int ALPHA_FRAC = 15;
    localparam int OUT_FRAC   = 8;

    localparam logic [GAIN_W-1:0] ALPHA_ONE = 16'h8000;  // 1.0 in Q1.15
    localparam int ROUND_Q15 = 16384;
    localparam int ROUND_Q8  = 128;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_THR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd7;

    typedef struct packed {
        logic [GAIN_W-1:0] setpoint;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [MAG_W-1:0]  drive_limit;
        logic [MAG_W-1:0]  dead_band;
        logic [MAG_W-1:0]  sep_thr;
        logic [GAIN_W-1:0] alpha;
    } cfg_t;

    // operand pair for the shared multiplier
    typedef enum logic [2:0] {
        MUL_KD_DIFF = 3'd0,
        MUL_KP_ERR  = 3'd1,
        MUL_ALPHA_D = 3'd2,
        MUL_BETA_SD = 3'd3,
        MUL_KI_INT  = 3'd4
    } mul_sel_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     idle;
        logic     upd_int;
        logic     ld_d;
        logic     ld_tot;
        logic     ld_fil;
        logic     add_fil;
        logic     add_tot;
        logic     ld_sd;
        logic     add_sd;
        logic     ld_out;
    } step_t;

endpackage

// ----- rtl/core/pds_cfg.sv -----
// ---------------------------------------------------------------------------
// pds_cfg
// Configuration register file, write only.
// ---------------------------------------------------------------------------
module pds_cfg
    import pds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setpoint    <= '0;
            cfg_reg.gain_p      <= '0;
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.drive_limit <= '1;
            cfg_reg.dead_band   <= '0;
            cfg_reg.sep_thr     <= '1;
            cfg_reg.alpha       <= ALPHA_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SETPOINT: cfg_reg.setpoint    <= cfg_wdata;
                REG_GAIN_P:   cfg_reg.gain_p      <= cfg_wdata;
                REG_GAIN_I:   cfg_reg.gain_i      <= cfg_wdata;
                REG_GAIN_D:   cfg_reg.gain_d      <= cfg_wdata;
                REG_LIMIT:    cfg_reg.drive_limit <= cfg_wdata[MAG_W-1:0];
                REG_DEADBAND: cfg_reg.dead_band   <= cfg_wdata[MAG_W-1:0];
                REG_SEP_THR:  cfg_reg.sep_thr     <= cfg_wdata[MAG_W-1:0];
                REG_ALPHA:    cfg_reg.alpha       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/pds_mul.sv -----
// ---------------------------------------------------------------------------
// pds_mul
// Shared signed multiplier with registered product.
// ---------------------------------------------------------------------------
module pds_mul #(
    parameter int A_W = 17,
    parameter int B_W = 33
) (
    input  logic                   aclk,
    input  logic signed [A_W-1:0]  op_a,
    input  logic signed [B_W-1:0]  op_b,
    output logic signed [A_W+B_W-1:0] prod
);

    logic signed [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/core/pds_seq.sv -----
// ---------------------------------------------------------------------------
// pds_seq
// Step sequencer: orders the five products and the accumulations.
// ---------------------------------------------------------------------------
module pds_seq
    import pds_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  logic  out_free,
    output step_t step
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_KD   = 9'b000000010,
        ST_KP   = 9'b000000100,
        ST_AL   = 9'b000001000,
        ST_BE   = 9'b000010000,
        ST_KI   = 9'b000100000,
        ST_FL   = 9'b001000000,
        ST_SM   = 9'b010000000,
        ST_OT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step         = '0;
        step.mul_sel = MUL_KD_DIFF;
        unique case (state_reg)
            ST_IDLE: begin
                step.idle = 1'b1;
                if (s_tvalid) state_next = ST_KD;
            end
            ST_KD: begin
                step.mul_sel = MUL_KD_DIFF;
                step.upd_int = 1'b1;
                state_next   = ST_KP;
            end
            ST_KP: begin
                step.mul_sel = MUL_KP_ERR;
                step.ld_d    = 1'b1;
                state_next   = ST_AL;
            end
            ST_AL: begin
                step.mul_sel = MUL_ALPHA_D;
                step.ld_tot  = 1'b1;
                state_next   = ST_BE;
            end
            ST_BE: begin
                step.mul_sel = MUL_BETA_SD;
                step.ld_fil  = 1'b1;
                state_next   = ST_KI;
            end
            ST_KI: begin
                step.mul_sel = MUL_KI_INT;
                step.add_fil = 1'b1;
                state_next   = ST_FL;
            end
            ST_FL: begin
                step.add_tot = 1'b1;
                step.ld_sd   = 1'b1;
                state_next   = ST_SM;
            end
            ST_SM: begin
                step.add_sd = 1'b1;
                state_next  = ST_OT;
            end
            ST_OT: begin
                if (out_free) begin
                    step.ld_out = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/core/pid_deadzone_separation.sv -----
// ---------------------------------------------------------------------------
// pid_deadzone_separation
// Fixed-point PID step with dead band, integral separation and a low-pass
// filtered derivative, built around one shared multiplier.
// ---------------------------------------------------------------------------
// Sequence: an accepted word steps the sequencer through KD, KP, AL, BE,
// KI, FL, SM and OT; m_tvalid rises when OT finds the output register free.
// A new word is taken only once the last one is done; five products go one
// after another through the single 17 x 32 bit multiplier, with its
// registered output. s_tready is high only while the sequencer is idle; a
// finished result waits in the output register and does not block the next
// word. Reset (aresetn low, synchronous): registers to their reset values,
// error history, integral and derivative filter cleared, output channel empty.
module pid_deadzone_separation
    import pds_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int ACC_WIDTH  = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  logic                 s_tuser,   // [0] func: 0 measurement, 1 error
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata,   // [15:0] drive
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int DW    = DATA_WIDTH;
    localparam int AW    = ACC_WIDTH;
    localparam int DW1   = DW + 1;
    localparam int IW    = ((AW > DW) ? AW : DW) + 1;   // integral sum before saturation
    localparam int MB_T  = (DW1 > AW) ? DW1 : AW;
    localparam int MB_W  = (MB_T > DERIV_W) ? MB_T : DERIV_W;
    localparam int PW    = MUL_A_W + MB_W;
    localparam int TOT_W = PW + 2;
    localparam int FIL_W = MUL_A_W + DERIV_W;           // Q1.15 weighted sum
    localparam int SH_W  = FIL_W - ALPHA_FRAC;
    localparam int YW    = TOT_W - OUT_FRAC;

    localparam logic [DW-1:0]      ERR_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0]      ERR_MAX = ~ERR_MIN;
    localparam logic [AW-1:0]      ACC_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic [AW-1:0]      ACC_MAX = ~ACC_MIN;
    localparam logic [DERIV_W-1:0] D_MIN   = {1'b1, {(DERIV_W-1){1'b0}}};
    localparam logic [DERIV_W-1:0] D_MAX   = ~D_MIN;

    cfg_t  cfg;
    step_t step;

    logic in_accept;
    logic out_free;

    // state kept across words
    logic signed [DW-1:0]      last_err_reg;
    logic signed [AW-1:0]      int_reg, int_next;
    logic signed [DERIV_W-1:0] sd_reg, sd_next;

    // per-word working registers
    logic                      func_reg;
    logic signed [DW-1:0]      e_reg;
    logic signed [DERIV_W-1:0] d_reg, d_next;
    logic signed [FIL_W-1:0]   fil_reg;
    logic signed [TOT_W-1:0]   tot_reg;

    logic                      m_tvalid_reg;
    logic [SAMPLE_W-1:0]       m_tdata_reg;

    pds_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pds_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .step     (step)
    );

    assign s_tready  = step.idle;
    assign in_accept = s_tvalid & step.idle;
    assign out_free  = ~m_tvalid_reg | m_tready;

    // ---- error at accept: difference or direct, saturate, dead band ----
    logic signed [WIDE_W-1:0] err_raw;
    logic                     err_fits;
    logic signed [DW-1:0]     err_sat;
    logic signed [SAMPLE_W-1:0] db_s;
    logic                     in_band;
    logic signed [DW-1:0]     e_in;

    assign err_raw  = s_tuser ? WIDE_W'($signed(s_tdata))
                              : WIDE_W'($signed(cfg.setpoint)) - WIDE_W'($signed(s_tdata));
    assign err_fits = (&err_raw[WIDE_W-1:DW-1]) | ~(|err_raw[WIDE_W-1:DW-1]);
    assign err_sat  = err_fits ? err_raw[DW-1:0] : (err_raw[WIDE_W-1] ? ERR_MIN : ERR_MAX);
    assign db_s     = $signed({1'b0, cfg.dead_band});
    // nonzero errors strictly inside the band are dropped
    assign in_band  = ((err_sat > 0) && (err_sat < db_s)) ||
                      ((err_sat < 0) && (err_sat > -db_s));
    assign e_in     = in_band ? '0 : err_sat;

    // ---- integral with saturation and separation ----
    logic signed [IW-1:0]       isum;
    logic                       int_fits;
    logic signed [SAMPLE_W-1:0] thr_s;
    logic                       int_clr;

    assign isum     = IW'(int_reg) + IW'(e_reg);
    assign int_fits = (&isum[IW-1:AW-1]) | ~(|isum[IW-1:AW-1]);
    assign thr_s    = $signed({1'b0, cfg.sep_thr});
    // large error, or measurement mode with no integral gain, clears the sum
    assign int_clr  = (e_reg > thr_s) || (e_reg < -thr_s) ||
                      (!func_reg && (cfg.gain_i == '0));
    assign int_next = int_clr ? '0
                    : (int_fits ? isum[AW-1:0] : (isum[IW-1] ? ACC_MIN : ACC_MAX));

    // ---- shared multiplier operands ----
    logic [GAIN_W-1:0]          alpha_sat;
    logic [MUL_A_W-1:0]         beta;
    logic signed [DW1-1:0]      diff;
    logic signed [MUL_A_W-1:0]  op_a;
    logic signed [MB_W-1:0]     op_b;
    logic signed [PW-1:0]       prod;

    assign alpha_sat = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    assign beta      = {1'b0, ALPHA_ONE} - {1'b0, alpha_sat};   // 1 - alpha
    assign diff      = DW1'(e_reg) - DW1'(last_err_reg);

    always_comb begin
        case (step.mul_sel)
            MUL_KD_DIFF: begin
                op_a = MUL_A_W'($signed(cfg.gain_d));
                op_b = MB_W'(diff);
            end
            MUL_KP_ERR: begin
                op_a = MUL_A_W'($signed(cfg.gain_p));
                op_b = MB_W'(e_reg);
            end
            MUL_ALPHA_D: begin
                op_a = $signed({1'b0, alpha_sat});
                op_b = MB_W'(d_reg);
            end
            MUL_BETA_SD: begin
                op_a = $signed(beta);
                op_b = MB_W'(sd_reg);
            end
            MUL_KI_INT: begin
                op_a = MUL_A_W'($signed(cfg.gain_i));
                op_b = MB_W'(int_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    pds_mul #(
        .A_W (MUL_A_W),
        .B_W (MB_W)
    ) u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // ---- saturations of the derivative and of the filter output ----
    logic                     d_fits;
    logic signed [SH_W-1:0]   fil_sh;
    logic                     sd_fits;

    assign d_fits  = (&prod[PW-1:DERIV_W-1]) | ~(|prod[PW-1:DERIV_W-1]);
    assign d_next  = d_fits ? prod[DERIV_W-1:0] : (prod[PW-1] ? D_MIN : D_MAX);
    assign fil_sh  = fil_reg[FIL_W-1:ALPHA_FRAC];             // floor by 2^15
    assign sd_fits = (&fil_sh[SH_W-1:DERIV_W-1]) | ~(|fil_sh[SH_W-1:DERIV_W-1]);
    assign sd_next = sd_fits ? fil_sh[DERIV_W-1:0] : (fil_sh[SH_W-1] ? D_MIN : D_MAX);

    // ---- output rounding and clamp ----
    logic signed [TOT_W-1:0]    tot_rnd;
    logic signed [YW-1:0]       y_wide;
    logic signed [SAMPLE_W-1:0] lim_s;
    logic signed [SAMPLE_W-1:0] drive;

    assign tot_rnd = tot_reg + TOT_W'(ROUND_Q8);
    assign y_wide  = tot_rnd[TOT_W-1:OUT_FRAC];
    assign lim_s   = $signed({1'b0, cfg.drive_limit});

    always_comb begin
        if (y_wide > lim_s) begin
            drive = lim_s;
        end else if (y_wide < -lim_s) begin
            drive = -lim_s;
        end else begin
            drive = y_wide[SAMPLE_W-1:0];
        end
    end

    // ---- controller state ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
            int_reg      <= '0;
            sd_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (step.upd_int) begin
                int_reg      <= int_next;
                last_err_reg <= e_reg;
            end
            if (step.ld_sd) sd_reg <= sd_next;
            if (step.ld_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---- working registers ----
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            func_reg <= s_tuser;
            e_reg    <= e_in;
        end
        if (step.ld_d)    d_reg   <= d_next;
        if (step.ld_fil)  fil_reg <= FIL_W'(prod) + FIL_W'(ROUND_Q15);
        if (step.add_fil) fil_reg <= fil_reg + FIL_W'(prod);
        if (step.ld_tot)  tot_reg <= TOT_W'(prod);
        if (step.add_tot) tot_reg <= tot_reg + TOT_W'(prod);
        if (step.add_sd)  tot_reg <= tot_reg + TOT_W'(sd_reg);
        if (step.ld_out)  m_tdata_reg <= drive;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
